@@ sv/x86il_pkg.sv @@
// Package: decoder phases, opcode flag kinds, flag bits and opcode flag tables.
package x86il_pkg;

  localparam int MaxLength = 15;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_ESC    = 3'd1,
    PH_MODRM  = 3'd2,
    PH_SIB    = 3'd3,
    PH_DISP   = 3'd4,
    PH_IMM    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    SZ2 = 2'd0,
    SZ4 = 2'd1,
    SZ8 = 2'd2
  } size_t;

  localparam logic [7:0] KM   = 8'h01;
  localparam logic [7:0] K8   = 8'h02;
  localparam logic [7:0] K16  = 8'h04;
  localparam logic [7:0] K64  = 8'h08;
  localparam logic [7:0] KV   = 8'h10;
  localparam logic [7:0] KR8  = 8'h20;
  localparam logic [7:0] KR32 = 8'h40;
  localparam logic [7:0] KG   = 8'h80;
  localparam logic [7:0] KX   = 8'hFF;

  localparam logic [10:0] FL_MODRM  = 11'h001;
  localparam logic [10:0] FL_SIB    = 11'h002;
  localparam logic [10:0] FL_DISP8  = 11'h004;
  localparam logic [10:0] FL_DISP32 = 11'h008;
  localparam logic [10:0] FL_IMM8   = 11'h010;
  localparam logic [10:0] FL_IMM16  = 11'h020;
  localparam logic [10:0] FL_IMM32  = 11'h040;
  localparam logic [10:0] FL_IMM64  = 11'h080;
  localparam logic [10:0] FL_REL    = 11'h100;
  localparam logic [10:0] FL_ERR    = 11'h200;
  localparam logic [10:0] FL_LONG   = 11'h400;

  localparam logic [7:0] OP_ESC  = 8'h0F;
  localparam logic [7:0] OP_GRP6 = 8'hF6;
  localparam logic [7:0] OP_GRP7 = 8'hF7;

  function automatic logic [7:0] one_tab(input logic [7:0] b);
    logic [7:0] f;
    f = 8'h00;
    if (b < 8'h40) begin
      case (b[2:0])
        3'd0, 3'd1, 3'd2, 3'd3: f = KM;
        3'd4: f = K8;
        3'd5: f = KV;
        default: f = 8'h00;
      endcase
    end else if (b >= 8'h70 && b <= 8'h7F) begin
      f = KR8;
    end else if (b >= 8'h84 && b <= 8'h8F) begin
      f = KM;
    end else if (b >= 8'hA0 && b <= 8'hA3) begin
      f = K64;
    end else if (b >= 8'hB0 && b <= 8'hB7) begin
      f = K8;
    end else if (b >= 8'hB8 && b <= 8'hBF) begin
      f = K64;
    end else if (b >= 8'hD8 && b <= 8'hDF) begin
      f = KM;
    end else begin
      case (b)
        8'h62, 8'h63: f = KM;
        8'h68: f = KV;
        8'h69: f = KM | KV;
        8'h6A: f = K8;
        8'h6B: f = KM | K8;
        8'h80, 8'h82, 8'h83: f = KM | K8;
        8'h81: f = KM | KV;
        8'hA8: f = K8;
        8'hA9: f = KV;
        8'hC0, 8'hC1, 8'hC6: f = KM | K8;
        8'hC2, 8'hCA: f = K16;
        8'hC4, 8'hC5: f = KM;
        8'hC7: f = KM | KV;
        8'hC8: f = K16 | K8;
        8'hCD: f = K8;
        8'hD0, 8'hD1, 8'hD2, 8'hD3: f = KM;
        8'hD4, 8'hD5: f = K8;
        8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hEB: f = KR8;
        8'hE4, 8'hE5, 8'hE6, 8'hE7: f = K8;
        8'hE8, 8'hE9: f = KR32;
        8'hF6, 8'hF7: f = KM | KG;
        8'hFE, 8'hFF: f = KM;
        default: f = 8'h00;
      endcase
    end
    return f;
  endfunction

  function automatic logic [7:0] two_tab(input logic [7:0] b);
    logic [7:0] f;
    f = KM;
    if (b >= 8'h80 && b <= 8'h8F) begin
      f = KR32;
    end else if (b >= 8'hC8 && b <= 8'hCF) begin
      f = 8'h00;
    end else begin
      case (b)
        8'h04, 8'h0A, 8'h0C, 8'h24, 8'h25, 8'h26, 8'h27, 8'h36, 8'h39,
        8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'hA6, 8'hA7, 8'hFF: f = KX;
        8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h0E,
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h37,
        8'hA0, 8'hA1, 8'hA2, 8'hA8, 8'hA9, 8'hAA: f = 8'h00;
        8'h0F, 8'h70, 8'h71, 8'h72, 8'h73, 8'hA4, 8'hAC, 8'hBA,
        8'hC2, 8'hC4, 8'hC5, 8'hC6: f = KM | K8;
        default: f = KM;
      endcase
    end
    return f;
  endfunction

endpackage

@@ sv/x86_64_instruction_length_decoder_unit.sv @@
// Top level: byte-serial x86-64 instruction length decoder.
//
//  channel  dir  signals
//  in       in   in_valid, in_ready, code_byte, restart
//  out      out  out_valid, out_ready, instr_length .. prefix_marks
//
// One code byte per cycle; the decode state updates in the cycle the byte is taken.
// The byte that ends an instruction loads the output register; the result is valid
// from the next cycle. in_ready is low while a result waits and out_ready is low.
// rst is synchronous and clears the decode state and the output valid.
module x86_64_instruction_length_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  instr_length,
  output logic [10:0] flag_bits,
  output logic [7:0]  opcode_byte,
  output logic [7:0]  second_opcode,
  output logic [7:0]  modrm_value,
  output logic [7:0]  sib_value,
  output logic [31:0] displacement,
  output logic [63:0] immediate,
  output logic [7:0]  rex_value,
  output logic [7:0]  rep_prefix,
  output logic [7:0]  segment_prefix,
  output logic [2:0]  prefix_marks
);

  x86il_pkg::phase_t phase, phase_next;
  logic [3:0]  bytes_seen, bytes_seen_next;
  logic [3:0]  field_left, field_left_next;
  logic [2:0]  field_pos, field_pos_next;
  logic [7:0]  pending, pending_next;
  x86il_pkg::size_t size_mode, size_mode_next;
  logic        wide_rex, wide_rex_next;
  logic        escape_seen, escape_seen_next;
  logic [63:0] imm, imm_next;
  logic [31:0] disp, disp_next;
  logic [7:0]  op, op_next, op2, op2_next, mrm, mrm_next, sib, sib_next;
  logic [7:0]  rex, rex_next, rep, rep_next, seg, seg_next;
  logic [2:0]  marks, marks_next;
  logic [10:0] flags, flags_next;
  logic        done;
  logic        emit;
  logic        accept;

  // Opens the next pending immediate; returns 1 if none left.
  function automatic logic next_imm(
    inout logic [7:0] pk, inout logic [10:0] fl, input x86il_pkg::size_t sz,
    input logic wr, inout x86il_pkg::phase_t ph, inout logic [3:0] n,
    inout logic [2:0] pos);
    logic r;
    r = 1'b0;
    if ((pk & x86il_pkg::K8) != 8'h00) begin
      pk = pk & ~x86il_pkg::K8; fl = fl | x86il_pkg::FL_IMM8; n = 4'd1;
    end else if ((pk & x86il_pkg::K16) != 8'h00) begin
      pk = pk & ~x86il_pkg::K16; fl = fl | x86il_pkg::FL_IMM16; n = 4'd2;
    end else if ((pk & x86il_pkg::KV) != 8'h00) begin
      pk = pk & ~x86il_pkg::KV;
      if (sz == x86il_pkg::SZ2) begin
        fl = fl | x86il_pkg::FL_IMM16; n = 4'd2;
      end else begin
        fl = fl | x86il_pkg::FL_IMM32; n = 4'd4;
      end
    end else if ((pk & x86il_pkg::K64) != 8'h00) begin
      pk = pk & ~x86il_pkg::K64;
      if (wr) begin
        fl = fl | x86il_pkg::FL_IMM64; n = 4'd8;
      end else if (sz == x86il_pkg::SZ2) begin
        fl = fl | x86il_pkg::FL_IMM16; n = 4'd2;
      end else begin
        fl = fl | x86il_pkg::FL_IMM32; n = 4'd4;
      end
    end else begin
      r = 1'b1;
    end
    if (!r) begin
      ph = x86il_pkg::PH_IMM; pos = 3'd0;
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  f;
    logic [1:0]  md;
    logic        abs32;
    logic        go_disp;
    logic [5:0]  sh;
    b = code_byte;
    f = 8'h00;
    md = 2'd0;
    abs32 = 1'b0;
    go_disp = 1'b0;
    sh = 6'd0;
    done = 1'b0;
    if (restart) begin
      phase_next = x86il_pkg::PH_PREFIX; bytes_seen_next = 4'd0; field_left_next = 4'd0;
      field_pos_next = 3'd0; pending_next = 8'h00; size_mode_next = x86il_pkg::SZ4;
      wide_rex_next = 1'b0; escape_seen_next = 1'b0; imm_next = '0; disp_next = '0;
      op_next = '0; op2_next = '0; mrm_next = '0; sib_next = '0; rex_next = '0;
      rep_next = '0; seg_next = '0; marks_next = '0; flags_next = '0;
    end else begin
      phase_next = phase; bytes_seen_next = bytes_seen; field_left_next = field_left;
      field_pos_next = field_pos; pending_next = pending; size_mode_next = size_mode;
      wide_rex_next = wide_rex; escape_seen_next = escape_seen; imm_next = imm;
      disp_next = disp; op_next = op; op2_next = op2; mrm_next = mrm; sib_next = sib;
      rex_next = rex; rep_next = rep; seg_next = seg; marks_next = marks;
      flags_next = flags;
    end
    bytes_seen_next = bytes_seen_next + 4'd1;
    f = 8'h00;
    case (phase_next)
      x86il_pkg::PH_PREFIX: begin
        if (b == 8'hF3 || b == 8'hF2) begin
          rep_next = b;
        end else if (b == 8'hF0) begin
          marks_next[0] = 1'b1;
        end else if (b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
                     b == 8'h64 || b == 8'h65) begin
          seg_next = b;
        end else if (b == 8'h66) begin
          marks_next[1] = 1'b1; size_mode_next = x86il_pkg::SZ2;
        end else if (b == 8'h67) begin
          marks_next[2] = 1'b1;
        end else if (b[7:4] == 4'h4) begin
          rex_next = b; wide_rex_next = b[3];
          if (b[3]) size_mode_next = x86il_pkg::SZ8;
        end else begin
          op_next = b;
          if (b == x86il_pkg::OP_ESC) begin
            escape_seen_next = 1'b1; phase_next = x86il_pkg::PH_ESC;
          end else begin
            f = x86il_pkg::one_tab(b);
          end
        end
      end
      x86il_pkg::PH_ESC: begin
        op2_next = b;
        f = x86il_pkg::two_tab(b);
      end
      x86il_pkg::PH_MODRM: begin
        mrm_next = b;
        flags_next = flags_next | x86il_pkg::FL_MODRM;
        if (!escape_seen_next && (op_next == x86il_pkg::OP_GRP6 ||
            op_next == x86il_pkg::OP_GRP7) && b[5:4] == 2'b00)
          pending_next = pending_next |
            ((op_next == x86il_pkg::OP_GRP6) ? x86il_pkg::K8 : x86il_pkg::KV);
        if (b[7:6] != 2'd3 && b[2:0] == 3'd4) begin
          phase_next = x86il_pkg::PH_SIB;
        end else begin
          go_disp = 1'b1; md = b[7:6]; abs32 = (b[7:6] == 2'd0) && (b[2:0] == 3'd5);
        end
      end
      x86il_pkg::PH_SIB: begin
        sib_next = b;
        flags_next = flags_next | x86il_pkg::FL_SIB;
        go_disp = 1'b1; md = mrm_next[7:6];
        abs32 = (mrm_next[7:6] == 2'd0) && (b[2:0] == 3'd5);
      end
      x86il_pkg::PH_DISP: begin
        sh = {1'b0, field_pos_next[1:0], 3'b000};
        disp_next = disp_next | (32'(b) << sh[4:0]);
        field_pos_next = field_pos_next + 3'd1;
        field_left_next = field_left_next - 4'd1;
        if (field_left_next == 4'd0)
          done = next_imm(pending_next, flags_next, size_mode_next, wide_rex_next,
                          phase_next, field_left_next, field_pos_next);
      end
      x86il_pkg::PH_IMM: begin
        sh = {field_pos_next, 3'b000};
        imm_next = (imm_next & ~(64'hFF << sh)) | (64'(b) << sh);
        field_pos_next = field_pos_next + 3'd1;
        field_left_next = field_left_next - 4'd1;
        if (field_left_next == 4'd0)
          done = next_imm(pending_next, flags_next, size_mode_next, wide_rex_next,
                          phase_next, field_left_next, field_pos_next);
      end
      default: ;
    endcase
    if (phase_next == x86il_pkg::PH_ESC && phase != x86il_pkg::PH_ESC && !restart ||
        phase_next == x86il_pkg::PH_ESC && restart && b == x86il_pkg::OP_ESC) begin
      // just entered escape: nothing more this byte
    end else if ((phase == x86il_pkg::PH_PREFIX || restart) && phase_next ==
                 x86il_pkg::PH_PREFIX && op_next == b && !(b == 8'hF3 || b == 8'hF2 ||
                 b == 8'hF0 || b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E ||
                 b == 8'h64 || b == 8'h65 || b == 8'h66 || b == 8'h67 ||
                 b[7:4] == 4'h4) || (!restart && phase == x86il_pkg::PH_ESC)) begin
      pending_next = 8'h00;
      if (f == x86il_pkg::KX) begin
        flags_next = flags_next | x86il_pkg::FL_ERR; done = 1'b1;
      end else if ((f & x86il_pkg::KR8) != 8'h00) begin
        flags_next = flags_next | x86il_pkg::FL_IMM8 | x86il_pkg::FL_REL;
        phase_next = x86il_pkg::PH_IMM; field_left_next = 4'd1; field_pos_next = 3'd0;
      end else if ((f & x86il_pkg::KR32) != 8'h00) begin
        flags_next = flags_next | x86il_pkg::FL_IMM32 | x86il_pkg::FL_REL;
        phase_next = x86il_pkg::PH_IMM; field_left_next = 4'd4; field_pos_next = 3'd0;
      end else begin
        pending_next = f;
        if ((f & x86il_pkg::KM) != 8'h00) begin
          phase_next = x86il_pkg::PH_MODRM;
        end else begin
          done = next_imm(pending_next, flags_next, size_mode_next, wide_rex_next,
                          phase_next, field_left_next, field_pos_next);
        end
      end
    end
    if (go_disp) begin
      if (abs32 || md == 2'd2) begin
        flags_next = flags_next | x86il_pkg::FL_DISP32;
        phase_next = x86il_pkg::PH_DISP; field_left_next = 4'd4; field_pos_next = 3'd0;
      end else if (md == 2'd1) begin
        flags_next = flags_next | x86il_pkg::FL_DISP8;
        phase_next = x86il_pkg::PH_DISP; field_left_next = 4'd1; field_pos_next = 3'd0;
      end else begin
        done = next_imm(pending_next, flags_next, size_mode_next, wide_rex_next,
                        phase_next, field_left_next, field_pos_next);
      end
    end
    emit = done || (bytes_seen_next >= 4'(x86il_pkg::MaxLength));
    if (!done && emit) flags_next = flags_next | x86il_pkg::FL_LONG;
  end

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= x86il_pkg::PH_PREFIX; bytes_seen <= '0; field_left <= '0; field_pos <= '0;
      pending <= '0; size_mode <= x86il_pkg::SZ4; wide_rex <= 1'b0; escape_seen <= 1'b0;
      imm <= '0; disp <= '0; op <= '0; op2 <= '0; mrm <= '0; sib <= '0; rex <= '0;
      rep <= '0; seg <= '0; marks <= '0; flags <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept) begin
        if (emit) begin
          out_valid <= 1'b1;
          instr_length <= bytes_seen_next; flag_bits <= flags_next;
          opcode_byte <= op_next; second_opcode <= op2_next; modrm_value <= mrm_next;
          sib_value <= sib_next; displacement <= disp_next; immediate <= imm_next;
          rex_value <= rex_next; rep_prefix <= rep_next; segment_prefix <= seg_next;
          prefix_marks <= marks_next;
          phase <= x86il_pkg::PH_PREFIX; bytes_seen <= '0; field_left <= '0;
          field_pos <= '0; pending <= '0; size_mode <= x86il_pkg::SZ4;
          wide_rex <= 1'b0; escape_seen <= 1'b0; imm <= '0; disp <= '0; op <= '0;
          op2 <= '0; mrm <= '0; sib <= '0; rex <= '0; rep <= '0; seg <= '0;
          marks <= '0; flags <= '0;
        end else begin
          phase <= phase_next; bytes_seen <= bytes_seen_next; field_left <= field_left_next;
          field_pos <= field_pos_next; pending <= pending_next;
          size_mode <= size_mode_next; wide_rex <= wide_rex_next;
          escape_seen <= escape_seen_next; imm <= imm_next; disp <= disp_next;
          op <= op_next; op2 <= op2_next; mrm <= mrm_next; sib <= sib_next;
          rex <= rex_next; rep <= rep_next; seg <= seg_next; marks <= marks_next;
          flags <= flags_next;
        end
      end
    end
  end

endmodule
